// File: design/srb_pkg.sv
// Package for the sample ring buffer with average and peak.
// Holds command codes, controller states and the controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package srb_pkg;

   // Command codes carried on the request channel; code 3 is ignored.
   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_LOAD,
      ST_WALK_START,
      ST_WALK,
      ST_DIV_START,
      ST_DIV,
      ST_FINISH
   } state_type;

   // Strobes from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic pop_load;
      logic walk_start;
      logic walk_step;
      logic div_start;
      logic div_step;
      logic finish_load;
   } ctrl_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic is_pop;
      logic walk_done;
      logic div_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: design/srb_if.sv
// Request and response channel interfaces of the sample ring buffer.
// Valid/ready handshake with the payload fields as separate signals; no dependencies.
`timescale 1ns / 1ps

interface srb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface srb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] value;
   logic [15:0] average;
   logic [15:0] peak;
   logic [4:0]  fill;

   modport source (output valid, output value, output average, output peak,
                   output fill, input ready);
   modport sink   (input valid, input value, input average, input peak,
                   input fill, output ready);
endinterface

// File: design/srb_controller.sv
// Sequencer of the sample ring buffer: one item at a time through execute,
// walk, divide and result load. Depends on srb_pkg.
`timescale 1ns / 1ps

module srb_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  srb_pkg::dp_status_type status,
   output srb_pkg::ctrl_cmd_type  ctrl
);

   srb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      ctrl      = '0;
      unique case (state_ff)
         srb_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = srb_pkg::ST_EXEC;
            end
         end
         srb_pkg::ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = status.is_pop ? srb_pkg::ST_POP_LOAD : srb_pkg::ST_WALK_START;
         end
         srb_pkg::ST_POP_LOAD: begin
            ctrl.pop_load = 1'b1;
            state_in      = srb_pkg::ST_WALK_START;
         end
         srb_pkg::ST_WALK_START: begin
            ctrl.walk_start = 1'b1;
            state_in        = srb_pkg::ST_WALK;
         end
         srb_pkg::ST_WALK: begin
            if (status.walk_done) begin
               state_in = srb_pkg::ST_DIV_START;
            end else begin
               ctrl.walk_step = 1'b1;
            end
         end
         srb_pkg::ST_DIV_START: begin
            ctrl.div_start = 1'b1;
            state_in       = srb_pkg::ST_DIV;
         end
         srb_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = srb_pkg::ST_FINISH;
            end else begin
               ctrl.div_step = 1'b1;
            end
         end
         srb_pkg::ST_FINISH: begin
            // Hold here until the response register is free.
            if (status.rsp_free) begin
               ctrl.finish_load = 1'b1;
               state_in         = srb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srb_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/srb_datapath.sv
// Datapath of the sample ring buffer: sample memory, ring pointers, peak,
// sum and maximum walk, restoring divider and response register. Depends on srb_pkg.
`timescale 1ns / 1ps

module srb_datapath #(
   parameter int DEPTH       = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srb_pkg::ctrl_cmd_type  ctrl,
   output srb_pkg::dp_status_type status,
   input  logic [1:0]             req_cmd,
   input  logic [15:0]            req_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [15:0]            rsp_value,
   output logic [15:0]            rsp_average,
   output logic [15:0]            rsp_peak,
   output logic [4:0]             rsp_fill
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int STEP_W = $clog2(SAMPLE_BITS + 1);

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(SAMPLE_BITS);

   logic [SAMPLE_BITS-1:0] mem [DEPTH];

   srb_pkg::cmd_type       cmd_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   logic [IDX_W-1:0]       oldest_ff, newest_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [SAMPLE_BITS-1:0] value_ff;
   logic                   pop_live_ff;
   logic                   rescan_ff;

   logic [IDX_W-1:0]       walk_ptr_ff;
   logic [CNT_W-1:0]       issue_cnt_ff;
   logic                   rd_pend_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SAMPLE_BITS-1:0] scan_ff;

   logic [CNT_W-1:0]       rem_ff;
   logic [SAMPLE_BITS-1:0] quo_ff;
   logic [STEP_W-1:0]      step_ff;

   logic                   rsp_valid_ff;
   logic [15:0]            rsp_value_ff, rsp_average_ff, rsp_peak_ff;
   logic [4:0]             rsp_fill_ff;

   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       push_newest;
   logic                   walk_issue;
   logic [CNT_W:0]         div_trial;
   logic                   div_ge;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? LAST_IDX : idx - 1'b1;
   endfunction

   // Memory ports.
   assign walk_issue  = ctrl.walk_step && (issue_cnt_ff != count_ff);
   assign push_newest = (count_ff != '0) ? idx_next(newest_ff) : newest_ff;
   assign wr_en       = ctrl.exec && (cmd_ff == srb_pkg::CMD_PUSH);
   assign wr_addr     = push_newest;
   assign rd_en       = walk_issue || (ctrl.exec && (cmd_ff == srb_pkg::CMD_POP));
   assign rd_addr     = ctrl.walk_step ? walk_ptr_ff : newest_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= sample_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Captured request.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff    <= srb_pkg::cmd_type'(req_cmd);
         sample_ff <= SAMPLE_BITS'(req_sample);
      end
   end

   // Ring state and peak.
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff  <= '0;
         peak_ff   <= '0;
      end else if (ctrl.exec) begin
         unique case (cmd_ff)
            srb_pkg::CMD_PUSH: begin
               newest_ff <= push_newest;
               if ((count_ff != '0) && (push_newest == oldest_ff)) begin
                  oldest_ff <= idx_next(oldest_ff);
               end
               if (sample_ff >= peak_ff) begin
                  peak_ff <= sample_ff;
               end
               if (count_ff != FULL_CNT) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
            srb_pkg::CMD_CLEAR: begin
               oldest_ff <= '0;
               newest_ff <= '0;
               count_ff  <= '0;
               peak_ff   <= '0;
            end
            default: begin
            end
         endcase
      end else if (ctrl.pop_load && pop_live_ff) begin
         count_ff <= count_ff - 1'b1;
         if (count_ff != CNT_W'(1)) begin
            newest_ff <= idx_prev(newest_ff);
         end
      end else if (ctrl.div_start && rescan_ff) begin
         peak_ff <= scan_ff;
      end
   end

   // Result value and rescan decision.
   always_ff @(posedge clock) begin
      if (ctrl.exec) begin
         value_ff    <= (cmd_ff == srb_pkg::CMD_PUSH) ? sample_ff : '0;
         pop_live_ff <= (cmd_ff == srb_pkg::CMD_POP) && (count_ff != '0);
         rescan_ff   <= 1'b0;
      end else if (ctrl.pop_load && pop_live_ff) begin
         value_ff  <= rd_data_ff;
         rescan_ff <= (rd_data_ff == peak_ff);
      end
   end

   // Walk over the held samples: one read issued per cycle, accumulated in the following cycle.
   always_ff @(posedge clock) begin
      if (ctrl.walk_start) begin
         walk_ptr_ff  <= oldest_ff;
         issue_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         sum_ff       <= '0;
         scan_ff      <= '0;
      end else if (ctrl.walk_step) begin
         rd_pend_ff <= walk_issue;
         if (walk_issue) begin
            walk_ptr_ff  <= idx_next(walk_ptr_ff);
            issue_cnt_ff <= issue_cnt_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            sum_ff <= sum_ff + SUM_W'(rd_data_ff);
            if (rd_data_ff >= scan_ff) begin
               scan_ff <= rd_data_ff;
            end
         end
      end
   end

   // Restoring divider, one quotient bit per cycle. The quotient never exceeds
   // the largest sample, so the top bits of the sum start as the remainder.
   assign div_trial = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign div_ge    = (div_trial >= {1'b0, count_ff});

   always_ff @(posedge clock) begin
      if (ctrl.div_start) begin
         rem_ff  <= sum_ff[SUM_W-1:SAMPLE_BITS];
         quo_ff  <= sum_ff[SAMPLE_BITS-1:0];
         step_ff <= '0;
      end else if (ctrl.div_step) begin
         quo_ff  <= {quo_ff[SAMPLE_BITS-2:0], div_ge};
         rem_ff  <= div_ge ? CNT_W'(div_trial - {1'b0, count_ff}) : div_trial[CNT_W-1:0];
         step_ff <= step_ff + 1'b1;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish_load) begin
         rsp_value_ff   <= 16'(value_ff);
         rsp_average_ff <= (count_ff == '0) ? 16'd0 : 16'(quo_ff);
         rsp_peak_ff    <= 16'(peak_ff);
         rsp_fill_ff    <= 5'(count_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_average = rsp_average_ff;
   assign rsp_peak    = rsp_peak_ff;
   assign rsp_fill    = rsp_fill_ff;

   assign status.is_pop    = (cmd_ff == srb_pkg::CMD_POP);
   assign status.walk_done = (issue_cnt_ff == count_ff) && !rd_pend_ff;
   assign status.div_done  = (step_ff == DIV_STEPS);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

endmodule

// File: design/sample_ring_buffer_avg_max_core.sv
// Top level of the sample ring buffer with running peak and floor average.
// Depends on srb_pkg, srb_if.sv, srb_controller and srb_datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake     Fields
// req_bus   in         valid/ready   cmd[1:0], sample[15:0]
// rsp_bus   out        valid/ready   value[15:0], average[15:0], peak[15:0], fill[4:0]
//
// Each item runs from acceptance to result through execute, a pop load for a pop,
// a walk over the held samples through the single memory read port, the
// one-bit-per-cycle divider and the result load. Reset is synchronous and empties
// the ring; the sample memory itself is not cleared. A new item is accepted in the
// cycle after the previous result is loaded into the response register; a stalled
// response holds the sequencer only when the next result is ready to be loaded.

module sample_ring_buffer_avg_max_core #(
   parameter int DEPTH       = 16,
   parameter int SAMPLE_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   srb_req_if.sink     req_bus,
   srb_rsp_if.source   rsp_bus
);

   srb_pkg::ctrl_cmd_type  ctrl;
   srb_pkg::dp_status_type status;

   // The controller owns sequencing and the request handshake.
   srb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   // The datapath owns all ring state, arithmetic and the response register.
   srb_datapath #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .status      (status),
      .req_cmd     (req_bus.cmd),
      .req_sample  (req_bus.sample),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_value   (rsp_bus.value),
      .rsp_average (rsp_bus.average),
      .rsp_peak    (rsp_bus.peak),
      .rsp_fill    (rsp_bus.fill)
   );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for sample_ring_buffer_avg_max_core.
// Depends on srb_pkg, the srb_req_if and srb_rsp_if interfaces, and the core itself.
`timescale 1ns / 1ps

module tb_top;

   localparam int RING_DEPTH = 16;

   // The fourth command code has no name in the package; the core ignores it.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] sample;
   } ring_cmd_type;

   typedef struct packed {
      logic [15:0] value;
      logic [15:0] average;
      logic [15:0] peak;
      logic [4:0]  fill;
   } ring_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   srb_req_if req_if ();
   srb_rsp_if rsp_if ();

   sample_ring_buffer_avg_max_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Commands waiting to be offered, and readings the core still owes us.
   ring_cmd_type     pending_cmds[$];
   ring_reading_type expected_readings[$];

   int   errors = 0;
   int   items_taken = 0;
   logic req_took = 1'b0;
   int   req_gap = 0;
   int   req_quiet = 0;
   int   rsp_stall = 0;
   int   rsp_quiet = 0;
   logic hold_off = 1'b0;
   ring_cmd_type next_cmd;

   // Shadow of the ring: samples, both ends, count and the running peak.
   logic [15:0] ring_mem [RING_DEPTH];
   logic [3:0]  oldest_pos = '0;
   logic [3:0]  newest_pos = '0;
   logic [4:0]  held = '0;
   logic [15:0] peak_now = '0;

   // Applies one command to the shadow ring and returns the reading it yields.
   function automatic ring_reading_type ring_apply(input logic [1:0] op,
                                                   input logic [15:0] smp);
      ring_reading_type r;
      int unsigned      total;
      logic [3:0]       idx;
      r.value = '0;
      case (op)
         srb_pkg::CMD_PUSH: begin
            // Appending to a full ring pushes the oldest end forward too.
            if (held != 0) begin
               newest_pos = newest_pos + 4'd1;
               if (newest_pos == oldest_pos) oldest_pos = oldest_pos + 4'd1;
            end
            ring_mem[newest_pos] = smp;
            if (smp >= peak_now) peak_now = smp;
            if (held < RING_DEPTH) held = held + 5'd1;
            r.value = smp;
         end
         srb_pkg::CMD_POP: begin
            // An empty pop changes nothing; the last pop leaves both ends alone.
            if (held != 0) begin
               held = held - 5'd1;
               r.value = ring_mem[newest_pos];
               if (held != 0) newest_pos = newest_pos - 4'd1;
               if (r.value == peak_now) begin
                  peak_now = '0;
                  for (int k = 0; k < held; k++) begin
                     idx = 4'(oldest_pos + k);
                     if (ring_mem[idx] >= peak_now) peak_now = ring_mem[idx];
                  end
               end
            end
         end
         srb_pkg::CMD_CLEAR: begin
            for (int k = 0; k < RING_DEPTH; k++) ring_mem[k] = '0;
            oldest_pos = '0;
            newest_pos = '0;
            held = '0;
            peak_now = '0;
         end
         default: ;
      endcase
      total = 0;
      for (int k = 0; k < held; k++) begin
         idx = 4'(oldest_pos + k);
         total += ring_mem[idx];
      end
      r.average = (held == 0) ? 16'd0 : 16'(total / held);
      r.peak = peak_now;
      r.fill = held;
      return r;
   endfunction

   // Mostly no gap or a short one, now and then a long one, and sometimes a quiet
   // stretch with no gaps at all.
   function automatic int pick_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         quiet = $urandom_range(40, 200);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   task automatic add_item(input logic [1:0] op, input logic [15:0] smp);
      ring_cmd_type c;
      c.op = op;
      c.sample = smp;
      pending_cmds.push_back(c);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Request driver: holds an item until it is taken, then waits out a random gap.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_took) begin
         // Item still on offer; keep it steady.
      end else if (req_gap > 0) begin
         req_gap--;
         req_if.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
         next_cmd = pending_cmds.pop_front();
         req_if.cmd <= next_cmd.op;
         req_if.sample <= next_cmd.sample;
         req_if.valid <= 1'b1;
         req_gap = pick_gap(req_quiet);
      end else begin
         req_if.valid <= 1'b0;
      end
      req_took = 1'b0;
   end

   // Response ready: random stalls, forced low during the long hold-off.
   always @(negedge clock) begin
      if (reset || hold_off) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_stall = pick_gap(rsp_quiet);
         rsp_if.ready <= (rsp_stall == 0);
      end
   end

   // Monitor: predicts on every accepted command and checks every accepted reading.
   always @(posedge clock) begin
      ring_reading_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            expected_readings.push_back(ring_apply(req_if.cmd, req_if.sample));
            req_took = 1'b1;
            items_taken++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_readings.size() == 0) begin
               $display("%0t: unexpected reading, expected none, actual value %0d fill %0d",
                        $time, rsp_if.value, rsp_if.fill);
               errors++;
            end else begin
               want = expected_readings.pop_front();
               check_field("value", want.value, rsp_if.value);
               check_field("average", want.average, rsp_if.average);
               check_field("peak", want.peak, rsp_if.peak);
               check_field("fill", {11'd0, want.fill}, {11'd0, rsp_if.fill});
            end
         end
      end
   end

   // Long receiver hold-off while commands keep coming, so the core backs up.
   initial begin
      while (items_taken < 400) @(posedge clock);
      hold_off <= 1'b1;
      repeat (500) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int          planned;
      int          counted;
      int          r;
      logic        draining;
      logic [1:0]  op;
      logic [15:0] smp;
      logic [15:0] recent;

      req_if.valid = 1'b0;
      req_if.cmd = srb_pkg::CMD_PUSH;
      req_if.sample = '0;
      rsp_if.ready = 1'b0;
      for (int k = 0; k < RING_DEPTH; k++) ring_mem[k] = '0;

      // Directed part: empty-ring corners, extremes, rescan on popping the peak,
      // overwrite of a full ring leaving the peak stale, the ignored code.
      add_item(srb_pkg::CMD_POP, 16'h1234);
      add_item(CMD_UNUSED, 16'hFFFF);
      add_item(srb_pkg::CMD_CLEAR, 16'hA5A5);
      add_item(srb_pkg::CMD_PUSH, 16'hFFFF);
      add_item(srb_pkg::CMD_PUSH, 16'h0000);
      add_item(srb_pkg::CMD_POP, 16'h0000);
      add_item(srb_pkg::CMD_POP, 16'h0000);
      add_item(srb_pkg::CMD_POP, 16'h0000);
      for (int k = 0; k <= RING_DEPTH; k++) begin
         smp = (k == 0) ? 16'hFFFF : 16'(k * 4099);
         add_item(srb_pkg::CMD_PUSH, smp);
      end
      add_item(srb_pkg::CMD_POP, 16'h0000);
      add_item(CMD_UNUSED, 16'h5A5A);
      add_item(srb_pkg::CMD_CLEAR, 16'h0000);

      // Random part: alternating fill and drain phases so the ring both wraps
      // and empties, with the odd clear and ignored code mixed in.
      counted = 0;
      draining = 1'b0;
      recent = '0;
      while (counted < 1600) begin
         if ($urandom_range(0, 19) == 0) draining = !draining;
         r = $urandom_range(0, 99);
         if (r < 2) op = srb_pkg::CMD_CLEAR;
         else if (r < 5) op = CMD_UNUSED;
         else if (draining) op = (r < 75) ? srb_pkg::CMD_POP : srb_pkg::CMD_PUSH;
         else op = (r < 20) ? srb_pkg::CMD_POP : srb_pkg::CMD_PUSH;
         case ($urandom_range(0, 9))
            0: smp = 16'hFFFF;
            1: smp = 16'h0000;
            2: smp = recent;
            3: smp = 16'($urandom_range(0, 15));
            4: smp = recent + 16'd1;
            default: smp = 16'($urandom);
         endcase
         if (op == srb_pkg::CMD_PUSH) recent = smp;
         add_item(op, smp);
         if (op != CMD_UNUSED) counted++;
      end
      planned = pending_cmds.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_taken < planned) @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      #1;
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
